// ===== src/rti_pkg.sv =====
// Shared widths, register codes and types for the ray-triangle intersection block
package rti_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIST_W    = 31;

    // edge and offset vectors: difference of two coordinates
    localparam int EDGE_W  = COORD_W + 1;
    // cross products (h and q), wide enough for the wider of the two
    localparam int CRS_W   = 2 * COORD_W + 3;
    // multiplier operand and product widths
    localparam int MUL_A_W = CRS_W;
    localparam int MUL_B_W = EDGE_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    // three-term dot products
    localparam int SUM_W   = MUL_P_W + 2;
    // divider remainder: numerator shifted by FRAC_BITS, compared to den << DIST_W
    localparam int REM_W   = SUM_W + DIST_W;

    localparam int MUL_LAT = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [CRS_W-1:0]   crs_t;
    typedef logic signed [MUL_P_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        edge_t [2:0] e1;
        edge_t [2:0] e2;
        edge_t [2:0] s;
    } edges_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic sat;
    } div_ctl_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } rsp_t;

    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } div_res_t;

endpackage

// ===== src/rti_if.sv =====
// Request and response channel interfaces of the ray-triangle intersection block
interface rti_tri_if import rti_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t vert0_x;
    coord_t vert0_y;
    coord_t vert0_z;
    coord_t vert1_x;
    coord_t vert1_y;
    coord_t vert1_z;
    coord_t vert2_x;
    coord_t vert2_y;
    coord_t vert2_z;

    modport source (output valid, output vert0_x, output vert0_y, output vert0_z,
                    output vert1_x, output vert1_y, output vert1_z,
                    output vert2_x, output vert2_y, output vert2_z, input ready);
    modport sink   (input valid, input vert0_x, input vert0_y, input vert0_z,
                    input vert1_x, input vert1_y, input vert1_z,
                    input vert2_x, input vert2_y, input vert2_z, output ready);
endinterface

interface rti_res_if import rti_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DIST_W-1:0] distance;

    modport source (output valid, output hit, output distance, input ready);
    modport sink   (input valid, input hit, input distance, output ready);
endinterface

// ===== src/rti_mul.sv =====
// Five-stage signed multiplier built from narrow partial products
module rti_mul import rti_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    localparam int AC_W  = 24;
    localparam int AC_N  = (MUL_A_W + AC_W - 1) / AC_W;
    localparam int BC_W  = 17;
    localparam int BC_N  = (MUL_B_W + BC_W - 1) / BC_W;
    localparam int PP_W  = AC_W + BC_W;
    localparam int ROW_W = PP_W + BC_W * (BC_N - 1);

    logic [MUL_A_W-1:0]     a_mag;
    logic [MUL_B_W-1:0]     b_mag;
    logic [AC_N*AC_W-1:0]   ma_reg;
    logic [BC_N*BC_W-1:0]   mb_reg;
    logic                   sgn1_reg, sgn2_reg, sgn3_reg, sgn4_reg;
    logic [PP_W-1:0]        pp_next [AC_N][BC_N];
    logic [PP_W-1:0]        pp_reg  [AC_N][BC_N];
    logic [ROW_W-1:0]       row_next [AC_N];
    logic [ROW_W-1:0]       row_reg  [AC_N];
    logic [MUL_P_W-1:0]     mag_next;
    logic [MUL_P_W-1:0]     mag_reg;
    logic signed [MUL_P_W-1:0] p_reg;

    // take magnitudes
    assign a_mag = a[MUL_A_W-1] ? MUL_A_W'(-a) : MUL_A_W'(a);
    assign b_mag = b[MUL_B_W-1] ? MUL_B_W'(-b) : MUL_B_W'(b);

    // form partial products and sum them by rows, then across rows
    always_comb
    begin
        for (int i = 0; i < AC_N; i++)
        begin
            for (int j = 0; j < BC_N; j++)
            begin
                pp_next[i][j] = PP_W'(ma_reg[i*AC_W +: AC_W]) * PP_W'(mb_reg[j*BC_W +: BC_W]);
            end
        end
        for (int i = 0; i < AC_N; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < BC_N; j++)
            begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) << (j * BC_W));
            end
        end
        mag_next = '0;
        for (int i = 0; i < AC_N; i++)
        begin
            mag_next = mag_next + (MUL_P_W'(row_reg[i]) << (i * AC_W));
        end
    end

    // advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= (AC_N*AC_W)'(a_mag);
            mb_reg   <= (BC_N*BC_W)'(b_mag);
            sgn1_reg <= a[MUL_A_W-1] ^ b[MUL_B_W-1];
            pp_reg   <= pp_next;
            sgn2_reg <= sgn1_reg;
            row_reg  <= row_next;
            sgn3_reg <= sgn2_reg;
            mag_reg  <= mag_next;
            sgn4_reg <= sgn3_reg;
            p_reg    <= sgn4_reg ? MUL_P_W'(-mag_reg) : MUL_P_W'(mag_reg);
        end
    end

    assign p = p_reg;

endmodule

// ===== src/rti_div.sv =====
// Pipelined restoring divider for the distance, one quotient bit per stage
module rti_div import rti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  div_ctl_t ctl_in,
    input  sum_t     num_in,
    input  sum_t     den_in,
    output div_res_t res
);

    logic [REM_W-1:0]  rem_src [DIST_W];
    logic [SUM_W-1:0]  den_src [DIST_W];
    logic [DIST_W-1:0] q_src   [DIST_W];
    div_ctl_t          ctl_src [DIST_W];
    logic [REM_W-1:0]  trial   [DIST_W];
    logic [REM_W-1:0]  rem_next [DIST_W];
    logic [DIST_W-1:0] q_next   [DIST_W];
    logic [REM_W-1:0]  rem_reg [DIST_W];
    logic [SUM_W-1:0]  den_reg [DIST_W];
    logic [DIST_W-1:0] q_reg   [DIST_W];
    div_ctl_t          ctl_reg [DIST_W];
    div_ctl_t          last_ctl;

    // one trial subtraction per stage, most significant quotient bit first
    always_comb
    begin
        for (int j = 0; j < DIST_W; j++)
        begin
            if (j == 0)
            begin
                rem_src[j] = REM_W'(num_in) << FRAC_BITS;
                den_src[j] = SUM_W'(den_in);
                q_src[j]   = '0;
                ctl_src[j] = ctl_in;
            end
            else
            begin
                rem_src[j] = rem_reg[j-1];
                den_src[j] = den_reg[j-1];
                q_src[j]   = q_reg[j-1];
                ctl_src[j] = ctl_reg[j-1];
            end
            trial[j]  = REM_W'(den_src[j]) << (DIST_W - 1 - j);
            q_next[j] = q_src[j];
            if (rem_src[j] >= trial[j])
            begin
                rem_next[j]             = rem_src[j] - trial[j];
                q_next[j][DIST_W-1-j]   = 1'b1;
            end
            else
            begin
                rem_next[j] = rem_src[j];
            end
        end
    end

    // hold control through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DIST_W; j++)
            begin
                ctl_reg[j] <= '0;
            end
        end
        else if (en)
        begin
            for (int j = 0; j < DIST_W; j++)
            begin
                ctl_reg[j] <= ctl_src[j];
            end
        end
    end

    // advance remainder, divisor and quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < DIST_W; j++)
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_src[j];
                q_reg[j]   <= q_next[j];
            end
        end
    end

    // drop the quotient on a miss, clamp on overflow
    assign last_ctl         = ctl_reg[DIST_W-1];
    assign res.valid        = last_ctl.valid;
    assign res.rsp.hit      = last_ctl.hit;
    assign res.rsp.distance = !last_ctl.hit ? '0 :
                              (last_ctl.sat ? '1 : q_reg[DIST_W-1]);

endmodule

// ===== src/ray_triangle_intersect.sv =====
// Top level of the fixed-point ray-triangle intersection pipeline
//
// The ray origin and direction sit in six configuration registers written
// through cfg_we / cfg_idx / cfg_data (indices 0..5: origin x,y,z then
// direction x,y,z, each signed Q16.16). Write them only while no request is
// in flight. Each request on req carries one triangle as three vertices;
// each yields exactly one response on rsp: hit, and the ray parameter t as
// unsigned Q15.16 truncated and saturated at its maximum (0 on a miss).
//
// A request is taken every cycle unless the output queue is full. The edge
// that accepts the request loads the input stage; then come two rounds of
// multipliers with a cross-product register between, dot-product
// sum, three compare stages, a 31-stage divider producing one quotient bit
// per stage, and the queue write.
// A two-entry output queue sits at the end; the whole pipeline stalls only
// when that queue is full, so req.ready depends on no combinational path
// from rsp.ready and nothing is lost or repeated under back-pressure.
// Reset clears the ray registers to zero and empties the pipeline and queue.
module ray_triangle_intersect import rti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rti_tri_if.sink               req,
    rti_res_if.source             rsp
);

    localparam int N_STG   = 2 * MUL_LAT + 6;
    localparam int X_IDX   = MUL_LAT + 1;
    localparam int FIFO_D  = 2;
    localparam int CNT_W   = $clog2(FIFO_D + 1);

    coord_t           origin_reg [3];
    coord_t           dir_reg    [3];
    logic             en;
    logic             req_acc;
    logic [N_STG-1:0] vld_reg;
    coord_t           v0 [3];
    coord_t           v1 [3];
    coord_t           v2 [3];
    edges_t           edg_next;
    edges_t           edg_reg [X_IDX+1];
    prod_t            mh_p [3];
    prod_t            mh_n [3];
    prod_t            mq_p [3];
    prod_t            mq_n [3];
    crs_t             h_reg [3];
    crs_t             q_reg [3];
    prod_t            ma [3];
    prod_t            mu [3];
    prod_t            mv [3];
    prod_t            mt [3];
    sum_t             da_reg, du_reg, dv_reg, dt_reg;
    sum_t             na_reg, nu_reg, nv_reg, nt_reg;
    logic             nzero_reg;
    sum_t             ca_reg, ct_reg, cuv_reg;
    logic             cpre_reg, csat_reg;
    logic [REM_W-1:0] num_w, lim_w;
    sum_t             fa_reg, ft_reg;
    logic             fhit_reg, fsat_reg;
    div_ctl_t         div_ctl;
    div_res_t         div_res;
    rsp_t             slot_reg [FIFO_D];
    logic [CNT_W-1:0] cnt_reg;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             push, pop;

    // write ray registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                origin_reg[k] <= '0;
                dir_reg[k]    <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ORIGIN_X: origin_reg[0] <= coord_t'(cfg_data);
                REG_ORIGIN_Y: origin_reg[1] <= coord_t'(cfg_data);
                REG_ORIGIN_Z: origin_reg[2] <= coord_t'(cfg_data);
                REG_DIR_X:    dir_reg[0]    <= coord_t'(cfg_data);
                REG_DIR_Y:    dir_reg[1]    <= coord_t'(cfg_data);
                REG_DIR_Z:    dir_reg[2]    <= coord_t'(cfg_data);
                default:      ;
            endcase
        end
    end

    // stall the whole pipeline only when the output queue is full
    assign en        = (cnt_reg != CNT_W'(FIFO_D));
    assign req.ready = en;
    assign req_acc   = req.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N_STG-2:0], req_acc};
        end
    end

    // form edges and origin offset
    assign v0[0] = req.vert0_x;
    assign v0[1] = req.vert0_y;
    assign v0[2] = req.vert0_z;
    assign v1[0] = req.vert1_x;
    assign v1[1] = req.vert1_y;
    assign v1[2] = req.vert1_z;
    assign v2[0] = req.vert2_x;
    assign v2[1] = req.vert2_y;
    assign v2[2] = req.vert2_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            edg_next.e1[k] = EDGE_W'(v1[k]) - EDGE_W'(v0[k]);
            edg_next.e2[k] = EDGE_W'(v2[k]) - EDGE_W'(v0[k]);
            edg_next.s[k]  = EDGE_W'(origin_reg[k]) - EDGE_W'(v0[k]);
        end
    end

    // carry edges alongside the first multiplier round
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            edg_reg[0] <= edg_next;
            for (int k = 1; k <= X_IDX; k++)
            begin
                edg_reg[k] <= edg_reg[k-1];
            end
        end
    end

    // h = dir x e2 and q = s x e1
    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int J1 = (i + 1) % 3;
        localparam int J2 = (i + 2) % 3;

        rti_mul u_mh_p (.clk(clk), .en(en), .a(CRS_W'(dir_reg[J1])),
                        .b($signed(edg_reg[0].e2[J2])), .p(mh_p[i]));
        rti_mul u_mh_n (.clk(clk), .en(en), .a(CRS_W'(dir_reg[J2])),
                        .b($signed(edg_reg[0].e2[J1])), .p(mh_n[i]));
        rti_mul u_mq_p (.clk(clk), .en(en), .a(CRS_W'($signed(edg_reg[0].s[J1]))),
                        .b($signed(edg_reg[0].e1[J2])), .p(mq_p[i]));
        rti_mul u_mq_n (.clk(clk), .en(en), .a(CRS_W'($signed(edg_reg[0].s[J2]))),
                        .b($signed(edg_reg[0].e1[J1])), .p(mq_n[i]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                h_reg[k] <= CRS_W'(mh_p[k] - mh_n[k]);
                q_reg[k] <= CRS_W'(mq_p[k] - mq_n[k]);
            end
        end
    end

    // a = e1.h, U = s.h, V = dir.q, T = e2.q
    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        rti_mul u_ma (.clk(clk), .en(en), .a(h_reg[i]),
                      .b($signed(edg_reg[X_IDX].e1[i])), .p(ma[i]));
        rti_mul u_mu (.clk(clk), .en(en), .a(h_reg[i]),
                      .b($signed(edg_reg[X_IDX].s[i])), .p(mu[i]));
        rti_mul u_mv (.clk(clk), .en(en), .a(q_reg[i]),
                      .b(EDGE_W'(dir_reg[i])), .p(mv[i]));
        rti_mul u_mt (.clk(clk), .en(en), .a(q_reg[i]),
                      .b($signed(edg_reg[X_IDX].e2[i])), .p(mt[i]));
    end

    // sum the dot products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da_reg <= SUM_W'(ma[0]) + SUM_W'(ma[1]) + SUM_W'(ma[2]);
            du_reg <= SUM_W'(mu[0]) + SUM_W'(mu[1]) + SUM_W'(mu[2]);
            dv_reg <= SUM_W'(mv[0]) + SUM_W'(mv[1]) + SUM_W'(mv[2]);
            dt_reg <= SUM_W'(mt[0]) + SUM_W'(mt[1]) + SUM_W'(mt[2]);
        end
    end

    // flip signs so that the determinant is non-negative
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nzero_reg <= (da_reg == '0);
            na_reg    <= da_reg[SUM_W-1] ? SUM_W'(-da_reg) : da_reg;
            nu_reg    <= da_reg[SUM_W-1] ? SUM_W'(-du_reg) : du_reg;
            nv_reg    <= da_reg[SUM_W-1] ? SUM_W'(-dv_reg) : dv_reg;
            nt_reg    <= da_reg[SUM_W-1] ? SUM_W'(-dt_reg) : dt_reg;
        end
    end

    // check the barycentric bounds, the sign of t and overflow of the distance
    assign num_w = REM_W'(nt_reg) << FRAC_BITS;
    assign lim_w = REM_W'(na_reg) << DIST_W;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpre_reg <= !nzero_reg && !nu_reg[SUM_W-1] && (nu_reg <= na_reg)
                        && !nv_reg[SUM_W-1] && !nt_reg[SUM_W-1] && (nt_reg != '0);
            csat_reg <= (num_w >= lim_w);
            cuv_reg  <= nu_reg + nv_reg;
            ca_reg   <= na_reg;
            ct_reg   <= nt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fhit_reg <= cpre_reg && (cuv_reg <= ca_reg);
            fsat_reg <= csat_reg;
            fa_reg   <= ca_reg;
            ft_reg   <= ct_reg;
        end
    end

    // divide t by the determinant
    assign div_ctl.valid = vld_reg[N_STG-1];
    assign div_ctl.hit   = fhit_reg;
    assign div_ctl.sat   = fsat_reg;

    rti_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_in (div_ctl),
        .num_in (ft_reg),
        .den_in (fa_reg),
        .res    (div_res)
    );

    // queue responses so the receiver can stall without losing one
    assign push = en && div_res.valid;
    assign pop  = rsp.valid && rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= div_res.rsp;
        end
    end

    assign rsp.valid    = (cnt_reg != '0);
    assign rsp.hit      = slot_reg[rd_ptr_reg].hit;
    assign rsp.distance = slot_reg[rd_ptr_reg].distance;

endmodule
